FILE: sv/l3d_pkg.sv
// ----------------------------------------------------------------------------
// l3d_pkg
// Shared widths, codes, types and the lerp helper of the 3D LUT sampler.
// ----------------------------------------------------------------------------
package l3d_pkg;

  localparam int MAX_GRID    = 33;
  localparam int FRAC_BITS   = 16;
  localparam int SAMPLE_W    = FRAC_BITS + 4;
  localparam int SCALE_W     = FRAC_BITS + 8;
  localparam int SIZE_W      = 6;
  localparam int INDEX_W     = 16;
  localparam int STORE_DEPTH = MAX_GRID * MAX_GRID * MAX_GRID;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int ENTRY_W     = 3 * SAMPLE_W;
  localparam int POS_RAW_W   = SAMPLE_W + SCALE_W - FRAC_BITS;
  localparam int POS_W       = SIZE_W + FRAC_BITS;
  localparam int ROW_W       = 2 * SIZE_W;
  localparam int LERP_W      = SAMPLE_W + FRAC_BITS + 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = SCALE_W;

  localparam logic [SIZE_W-1:0] SIZE_MIN = SIZE_W'(2);
  localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(MAX_GRID);

  // operation codes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LUT_SIZE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RED    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GREEN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_BLUE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_RED  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_GREEN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_BLUE = 3'd6;

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'((MAX_GRID - 1) * (1 << FRAC_BITS));

  typedef logic signed [SAMPLE_W-1:0] l3d_val_t;
  typedef l3d_val_t [2:0]             l3d_rgb_t;
  typedef l3d_rgb_t [7:0]             l3d_corner_t;

  typedef struct packed {
    logic                 operation;
    logic [INDEX_W-1:0]   entry_index;
    logic signed [SAMPLE_W-1:0] entry_red;
    logic signed [SAMPLE_W-1:0] entry_green;
    logic signed [SAMPLE_W-1:0] entry_blue;
    logic signed [SAMPLE_W-1:0] sample_red;
    logic signed [SAMPLE_W-1:0] sample_green;
    logic signed [SAMPLE_W-1:0] sample_blue;
  } l3d_req_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_red;
    logic signed [SAMPLE_W-1:0] out_green;
    logic signed [SAMPLE_W-1:0] out_blue;
  } l3d_res_t;

  typedef struct packed {
    logic [2:0][SAMPLE_W-1:0] dmin;
    logic [2:0][SCALE_W-1:0]  scale;
    logic [SIZE_W-1:0]        size;
  } l3d_cfg_t;

  typedef struct packed {
    logic                        valid;
    logic [2:0][SIZE_W-1:0]      lo;
    logic [2:0][SIZE_W-1:0]      hi;
    logic [2:0][FRAC_BITS-1:0]   t;
  } l3d_pos_t;

  typedef struct packed {
    logic                        valid;
    logic [7:0][ADDR_W-1:0]      addr;
    logic [2:0][FRAC_BITS-1:0]   t;
  } l3d_addr_t;

  typedef struct packed {
    logic                en;
    logic [ADDR_W-1:0]   addr;
    logic [ENTRY_W-1:0]  data;
  } l3d_wr_t;

  // a + round((b - a) * t / 2^F), halves toward plus infinity
  function automatic l3d_val_t l3d_lerp(input l3d_val_t a, input l3d_val_t b,
                                        input logic [FRAC_BITS-1:0] t);
    logic signed [SAMPLE_W:0]    diff;
    logic signed [FRAC_BITS:0]   tt;
    logic signed [LERP_W-1:0]    prod;
    logic signed [LERP_W-1:0]    sh;
    diff = SAMPLE_W'(0) + ({b[SAMPLE_W-1], b} - {a[SAMPLE_W-1], a});
    tt   = {1'b0, t};
    prod = LERP_W'(diff * tt) + LERP_W'(1 << (FRAC_BITS - 1));
    sh   = prod >>> FRAC_BITS;
    return l3d_val_t'(a + sh[SAMPLE_W-1:0]);
  endfunction

endpackage

FILE: sv/l3d_grid_map.sv
// ----------------------------------------------------------------------------
// l3d_grid_map
// Three stages: offset from domain minimum, scale, clamp and split per channel.
// ----------------------------------------------------------------------------
module l3d_grid_map import l3d_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  l3d_rgb_t          sample,
  input  l3d_cfg_t          cfg,
  output l3d_pos_t          pos
);

  logic                       v1_r, v2_r, v3_r;
  logic signed [SAMPLE_W:0]   d_r   [3];
  logic signed [SAMPLE_W:0]   d_nxt [3];
  logic [POS_RAW_W-1:0]       p_r   [3];
  logic [POS_RAW_W-1:0]       p_nxt [3];
  l3d_pos_t                   pos_r, pos_nxt;

  always_comb begin
    logic [SAMPLE_W+SCALE_W-1:0] prod;
    logic [POS_W-1:0]            limit;
    logic [POS_W-1:0]            pc;
    logic [SIZE_W:0]             lo_inc;
    prod    = '0;
    limit   = {cfg.size - SIZE_W'(1), {FRAC_BITS{1'b0}}};
    pc      = '0;
    lo_inc  = '0;
    pos_nxt = '0;
    for (int c = 0; c < 3; c++) begin
      d_nxt[c] = {sample[c][SAMPLE_W-1], sample[c]} -
                 {cfg.dmin[c][SAMPLE_W-1], cfg.dmin[c]};
      prod = d_r[c][SAMPLE_W-1:0] * cfg.scale[c];
      if (d_r[c] <= 0 || cfg.scale[c] == '0) begin
        p_nxt[c] = '0;
      end else begin
        p_nxt[c] = prod[SAMPLE_W+SCALE_W-1:FRAC_BITS];
      end
      pc = (p_r[c] > POS_RAW_W'(limit)) ? limit : p_r[c][POS_W-1:0];
      pos_nxt.lo[c] = pc[POS_W-1:FRAC_BITS];
      pos_nxt.t[c]  = pc[FRAC_BITS-1:0];
      lo_inc = {1'b0, pc[POS_W-1:FRAC_BITS]} + (SIZE_W+1)'(1);
      pos_nxt.hi[c] = (lo_inc < {1'b0, cfg.size}) ? lo_inc[SIZE_W-1:0]
                                                  : cfg.size - SIZE_W'(1);
    end
    pos_nxt.valid = v2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      d_r[c] <= d_nxt[c];
      p_r[c] <= p_nxt[c];
    end
    pos_r <= pos_nxt;
  end

  always_comb begin
    pos       = pos_r;
    pos.valid = v3_r;
  end

endmodule

FILE: sv/l3d_addr_gen.sv
// ----------------------------------------------------------------------------
// l3d_addr_gen
// Two stages: row offsets for the four blue/green pairs, then eight addresses.
// ----------------------------------------------------------------------------
module l3d_addr_gen import l3d_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  l3d_pos_t          pos,
  input  logic [SIZE_W-1:0] size,
  output l3d_addr_t         addr
);

  logic                       v4_r, v5_r;
  logic [ROW_W-1:0]           row_r   [4];
  logic [ROW_W-1:0]           row_nxt [4];
  logic [SIZE_W-1:0]          rlo_r, rhi_r;
  logic [2:0][FRAC_BITS-1:0]  t4_r;
  l3d_addr_t                  addr_r, addr_nxt;

  always_comb begin
    logic [SIZE_W-1:0]    b;
    logic [SIZE_W-1:0]    g;
    logic [ROW_W+SIZE_W-1:0] lin;
    b = '0;
    g = '0;
    lin = '0;
    addr_nxt = '0;
    // row j: bit0 picks upper green, bit1 upper blue
    for (int j = 0; j < 4; j++) begin
      b = j[1] ? pos.hi[2] : pos.lo[2];
      g = j[0] ? pos.hi[1] : pos.lo[1];
      row_nxt[j] = ROW_W'(b * size) + ROW_W'(g);
    end
    for (int k = 0; k < 8; k++) begin
      lin = (ROW_W+SIZE_W)'(row_r[k >> 1] * size) +
            (ROW_W+SIZE_W)'(k[0] ? rhi_r : rlo_r);
      addr_nxt.addr[k] = lin[ADDR_W-1:0];
    end
    addr_nxt.t = t4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v4_r <= pos.valid;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 4; j++) begin
      row_r[j] <= row_nxt[j];
    end
    rlo_r  <= pos.lo[0];
    rhi_r  <= pos.hi[0];
    t4_r   <= pos.t;
    addr_r <= addr_nxt;
  end

  always_comb begin
    addr       = addr_r;
    addr.valid = v5_r;
  end

endmodule

FILE: sv/l3d_corner_store.sv
// ----------------------------------------------------------------------------
// l3d_corner_store
// Table storage, four identical copies with two read ports each.
// ----------------------------------------------------------------------------
module l3d_corner_store import l3d_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  l3d_wr_t     wr,
  input  l3d_addr_t   addr,
  output logic        rd_valid,
  output l3d_corner_t corners
);

  logic [ENTRY_W-1:0] rd_r [8];
  logic               rd_valid_r;

  // every write lands in all copies so each corner has its own port
  for (genvar m = 0; m < 4; m++) begin : g_copy
    logic [ENTRY_W-1:0] mem [STORE_DEPTH];
    always_ff @(posedge clk) begin
      if (wr.en) begin
        mem[wr.addr] <= wr.data;
      end
      rd_r[2*m]   <= mem[addr.addr[2*m]];
      rd_r[2*m+1] <= mem[addr.addr[2*m+1]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= addr.valid;
    end
  end

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      corners[k][0] = rd_r[k][SAMPLE_W-1:0];
      corners[k][1] = rd_r[k][2*SAMPLE_W-1:SAMPLE_W];
      corners[k][2] = rd_r[k][3*SAMPLE_W-1:2*SAMPLE_W];
    end
  end

  assign rd_valid = rd_valid_r;

endmodule

FILE: sv/l3d_lerp_tree.sv
// ----------------------------------------------------------------------------
// l3d_lerp_tree
// Three stages of lerps: along red, then green, then blue.
// ----------------------------------------------------------------------------
module l3d_lerp_tree import l3d_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  l3d_corner_t               corners,
  input  logic [2:0][FRAC_BITS-1:0] t,
  output logic                      out_valid,
  output l3d_res_t                  out_res
);

  logic                    v7_r, v8_r, v9_r;
  l3d_rgb_t [3:0]          c1_r, c1_nxt;
  l3d_rgb_t [1:0]          c2_r, c2_nxt;
  l3d_rgb_t                c3_r, c3_nxt;
  logic [FRAC_BITS-1:0]    tg7_r, tb7_r, tb8_r;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int j = 0; j < 4; j++) begin
        c1_nxt[j][ch] = l3d_lerp(corners[2*j][ch], corners[2*j+1][ch], t[0]);
      end
      for (int j = 0; j < 2; j++) begin
        c2_nxt[j][ch] = l3d_lerp(c1_r[2*j][ch], c1_r[2*j+1][ch], tg7_r);
      end
      c3_nxt[ch] = l3d_lerp(c2_r[0][ch], c2_r[1][ch], tb8_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
      v8_r <= 1'b0;
      v9_r <= 1'b0;
    end else begin
      v7_r <= in_valid;
      v8_r <= v7_r;
      v9_r <= v8_r;
    end
  end

  always_ff @(posedge clk) begin
    c1_r  <= c1_nxt;
    c2_r  <= c2_nxt;
    c3_r  <= c3_nxt;
    tg7_r <= t[1];
    tb7_r <= t[2];
    tb8_r <= tb7_r;
  end

  assign out_valid         = v9_r;
  assign out_res.out_red   = c3_r[0];
  assign out_res.out_green = c3_r[1];
  assign out_res.out_blue  = c3_r[2];

endmodule

FILE: sv/lut3d_trilinear_sampler.sv
// ----------------------------------------------------------------------------
// lut3d_trilinear_sampler
// Colour 3D lookup table with trilinear interpolation.
// ----------------------------------------------------------------------------
// A request is taken at each rising edge with start high; busy is always low,
// so one request per clock is accepted. A write request (operation 0) stores
// one RGB entry at its linear index and returns nothing; indexes past the
// largest table are dropped. A sample request (operation 1) returns one
// interpolated colour on out_res, marked by out_valid for one cycle.
// Throughput is one request per cycle: the grid mapping, address
// generation and lerps are pipelined, and the eight corners come from
// four copies of the table with two read ports each. A write is visible to
// any sample accepted after it. Results are never held back, since the
// receiver cannot stall. Reset clears the pipeline and the registers (size 33,
// minimum 0, scale 32.0); table contents stay undefined until written.
// Configuration writes on cfg_we take effect at once and belong in idle time.
// ----------------------------------------------------------------------------
module lut3d_trilinear_sampler import l3d_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  l3d_req_t              in_req,
  output logic                  out_valid,
  output l3d_res_t              out_res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [SIZE_W-1:0]        lut_size_r;
  logic [2:0][SAMPLE_W-1:0] dmin_r;
  logic [2:0][SCALE_W-1:0]  scale_r;
  l3d_cfg_t                 cfg;
  logic                     accept;
  logic                     samp_valid;
  l3d_rgb_t                 sample;
  l3d_wr_t                  wr_nxt;
  logic [4:0]               wr_en_r;
  logic [ADDR_W-1:0]        wr_addr_r [5];
  logic [ENTRY_W-1:0]       wr_data_r [5];
  l3d_wr_t                  wr_d;
  l3d_pos_t                 pos;
  l3d_addr_t                addr;
  logic                     rd_valid;
  l3d_corner_t              corners;
  logic [2:0][FRAC_BITS-1:0] t6_r;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lut_size_r <= SIZE_W'(MAX_GRID);
      dmin_r     <= '0;
      scale_r    <= {3{SCALE_RESET}};
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LUT_SIZE:    lut_size_r <= cfg_wdata[SIZE_W-1:0];
        CFG_MIN_RED:     dmin_r[0]  <= cfg_wdata[SAMPLE_W-1:0];
        CFG_MIN_GREEN:   dmin_r[1]  <= cfg_wdata[SAMPLE_W-1:0];
        CFG_MIN_BLUE:    dmin_r[2]  <= cfg_wdata[SAMPLE_W-1:0];
        CFG_SCALE_RED:   scale_r[0] <= cfg_wdata;
        CFG_SCALE_GREEN: scale_r[1] <= cfg_wdata;
        CFG_SCALE_BLUE:  scale_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.dmin  = dmin_r;
    cfg.scale = scale_r;
    if (lut_size_r < SIZE_MIN) begin
      cfg.size = SIZE_MIN;
    end else if (lut_size_r > SIZE_MAX) begin
      cfg.size = SIZE_MAX;
    end else begin
      cfg.size = lut_size_r;
    end
  end

  assign samp_valid = accept && (in_req.operation == OP_SAMPLE);
  assign sample[0]  = in_req.sample_red;
  assign sample[1]  = in_req.sample_green;
  assign sample[2]  = in_req.sample_blue;

  always_comb begin
    wr_nxt.en   = accept && (in_req.operation == OP_WRITE) &&
                  ({1'b0, in_req.entry_index} < (INDEX_W+1)'(STORE_DEPTH));
    wr_nxt.addr = in_req.entry_index[ADDR_W-1:0];
    wr_nxt.data = {in_req.entry_blue, in_req.entry_green, in_req.entry_red};
  end

  // delay writes so they reach the table in step with sample reads
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_en_r <= '0;
    end else begin
      wr_en_r <= {wr_en_r[3:0], wr_nxt.en};
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r[0] <= wr_nxt.addr;
    wr_data_r[0] <= wr_nxt.data;
    for (int s = 1; s < 5; s++) begin
      wr_addr_r[s] <= wr_addr_r[s-1];
      wr_data_r[s] <= wr_data_r[s-1];
    end
    t6_r <= addr.t;
  end

  always_comb begin
    wr_d.en   = wr_en_r[4];
    wr_d.addr = wr_addr_r[4];
    wr_d.data = wr_data_r[4];
  end

  l3d_grid_map u_grid (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (samp_valid),
    .sample   (sample),
    .cfg      (cfg),
    .pos      (pos)
  );

  l3d_addr_gen u_addr (
    .clk   (clk),
    .rst_n (rst_n),
    .pos   (pos),
    .size  (cfg.size),
    .addr  (addr)
  );

  l3d_corner_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (wr_d),
    .addr     (addr),
    .rd_valid (rd_valid),
    .corners  (corners)
  );

  l3d_lerp_tree u_lerp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rd_valid),
    .corners   (corners),
    .t         (t6_r),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule
